// ===== hw/rtl/qdk_pkg.sv =====
package qdk_pkg;

  localparam int FRAC_BITS  = 14;
  localparam int COUNT_BITS = 16;

  localparam logic signed [15:0] UNIT_ONE =
    (FRAC_BITS > 14) ? 16'sh7FFF : 16'(1 << FRAC_BITS);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  typedef struct packed {
    logic signed [15:0] rot_w;
    logic signed [15:0] rot_x;
    logic signed [15:0] rot_y;
    logic signed [15:0] rot_z;
    logic               seq_start;
  } qdk_in_t;

  typedef struct packed {
    logic signed [15:0] out_w;
    logic signed [15:0] out_x;
    logic signed [15:0] out_y;
    logic signed [15:0] out_z;
    logic               kept;
    logic [15:0]        key_index;
    logic [15:0]        skipped_total;
  } qdk_out_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL, ST_SQRT, ST_DIV, ST_DONE, ST_OUT
  } qdk_state_t;

endpackage

// ===== hw/rtl/qdk_divider.sv =====
module qdk_divider (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [46:0] num,
  input  logic [38:0] den,
  output logic        done,
  output logic [46:0] quo
);
  import qdk_pkg::*;

  logic [46:0] quo_r, quo_nxt;
  logic [39:0] rem_r, rem_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic [38:0] den_r, den_nxt;
  logic [39:0] trial;
  logic        qbit;
  logic [46:0] step_quo;

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    den_nxt  = den_r;
    trial    = {rem_r[38:0], quo_r[46]};
    qbit     = (trial >= {1'b0, den_r});
    step_quo = {quo_r[45:0], qbit};
    if (start) begin
      quo_nxt  = num;
      rem_nxt  = '0;
      cnt_nxt  = 6'd47;
      busy_nxt = 1'b1;
      den_nxt  = den;
    end else if (busy_r) begin
      if (qbit) begin
        rem_nxt = trial - {1'b0, den_r};
      end else begin
        rem_nxt = trial;
      end
      quo_nxt = step_quo;
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign done = busy_r && (cnt_r == 6'd1);
  assign quo  = step_quo;

endmodule

// ===== hw/rtl/quaternion_deadband_keyframer.sv =====
// Accumulates rotation quaternions (Q2.14) as acc := q * acc, renormalizes,
// and emits a key when the new w falls below the limit written through cfg_data, else the
// identity. Each item runs the product and its rounding through one shared
// 18x18 multiplier, then the squared norm, 28 bit-pair square root steps and
// a hand-over, then four 47-step restoring divisions back to back through a
// shared divider, and settles the result. An item whose rounded product is
// zero skips the divisions. An item whose result finds the output register
// still held waits until it drains. A new item is taken only after the last
// has been handed to the output register: in_stall is high while an item is
// at work.
module quaternion_deadband_keyframer (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  qdk_pkg::qdk_in_t in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output qdk_pkg::qdk_out_t out_data,
  input  logic             cfg_we,
  input  logic [15:0]      cfg_data
);
  import qdk_pkg::*;

  qdk_state_t state_r, state_nxt;
  logic signed [15:0] lim_r;
  logic signed [15:0] acc_r [4];
  logic signed [15:0] q_r [4];
  logic [COUNT_BITS-1:0] key_r, skip_r;
  logic signed [34:0] P_r [4];
  logic signed [17:0] p_r [4];
  logic signed [15:0] o_r [4];
  logic [37:0] n2_r;
  logic [4:0]  step_r;
  logic [1:0]  comp_r;
  logic [55:0] sv_r;
  logic [55:0] sres_r;
  logic [55:0] sbit_r;
  logic        zero_r;
  qdk_out_t    out_r;
  logic        out_v_r;

  // shared multiplier
  logic signed [17:0] ma, mb;
  logic signed [35:0] mprod;
  assign mprod = ma * mb;

  logic [1:0] mi, mj;
  logic [1:0] aidx;
  logic       msub;
  assign mi = step_r[3:2];
  assign mj = step_r[1:0];

  always_comb begin
    aidx = 2'd0;
    msub = 1'b0;
    unique case ({mi, mj})
      4'h0: begin aidx = 2'd0; msub = 1'b0; end
      4'h1: begin aidx = 2'd1; msub = 1'b1; end
      4'h2: begin aidx = 2'd2; msub = 1'b1; end
      4'h3: begin aidx = 2'd3; msub = 1'b1; end
      4'h4: begin aidx = 2'd1; msub = 1'b0; end
      4'h5: begin aidx = 2'd0; msub = 1'b0; end
      4'h6: begin aidx = 2'd3; msub = 1'b0; end
      4'h7: begin aidx = 2'd2; msub = 1'b1; end
      4'h8: begin aidx = 2'd2; msub = 1'b0; end
      4'h9: begin aidx = 2'd3; msub = 1'b1; end
      4'hA: begin aidx = 2'd0; msub = 1'b0; end
      4'hB: begin aidx = 2'd1; msub = 1'b0; end
      4'hC: begin aidx = 2'd3; msub = 1'b0; end
      4'hD: begin aidx = 2'd2; msub = 1'b0; end
      4'hE: begin aidx = 2'd1; msub = 1'b1; end
      default: begin aidx = 2'd0; msub = 1'b0; end
    endcase
    if (state_r == ST_MUL) begin
      ma = 18'(q_r[mj]);
      mb = 18'(acc_r[aidx]);
    end else begin
      ma = p_r[step_r[1:0]];
      mb = p_r[step_r[1:0]];
    end
  end

  // rounding of P to p, half away from zero
  function automatic logic signed [17:0] rnd_p(input logic signed [34:0] v);
    logic [34:0] mag;
    logic [34:0] r;
    mag = v[34] ? 35'(-v) : 35'(v);
    r = (mag + 35'(1 << (FRAC_BITS-1))) >> FRAC_BITS;
    return v[34] ? -18'(r) : 18'(r);
  endfunction

  // divider
  logic        dv_start, dv_done;
  logic [46:0] dv_num, dv_quo;
  logic [38:0] dv_den;
  logic [1:0]  dv_comp;
  logic signed [34:0] Pc;
  logic signed [34:0] Pn;
  logic [34:0] Pmag;
  assign Pc      = P_r[comp_r];
  assign dv_comp = (state_r == ST_DIV) ? comp_r + 2'd1 : 2'd0;
  assign Pn      = P_r[dv_comp];
  assign Pmag    = Pn[34] ? 35'(-Pn) : 35'(Pn);
  assign dv_num = {4'd0, Pmag, 8'd0} + 47'(sres_r[27:1]);
  assign dv_den = {11'd0, sres_r[27:0]};
  assign dv_start = (state_r == ST_SQRT && step_r == 5'd4 && sbit_r == '0 && !zero_r)
                 || (state_r == ST_DIV && dv_done && comp_r != 2'd3);

  qdk_divider u_div (
    .clk(clk), .rst_n(rst_n), .start(dv_start),
    .num(dv_num), .den(dv_den), .done(dv_done), .quo(dv_quo)
  );

  logic signed [15:0] sat_o;
  always_comb begin
    if (Pc[34]) sat_o = (dv_quo > 47'd32768) ? 16'sh8000 : -16'(dv_quo);
    else        sat_o = (dv_quo > 47'd32767) ? 16'sh7FFF : 16'(dv_quo);
  end

  logic accept_in;
  assign accept_in = in_valid && !in_stall;
  assign in_stall  = (state_r != ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (accept_in) state_nxt = ST_MUL;
      ST_MUL:  if (step_r == 5'd16) state_nxt = ST_SQRT;
      ST_SQRT: if (sbit_r == '0 && step_r == 5'd4)
                 state_nxt = zero_r ? ST_DONE : ST_DIV;
      ST_DIV:  if (dv_done && comp_r == 2'd3) state_nxt = ST_DONE;
      ST_DONE: state_nxt = ST_OUT;
      ST_OUT:  if (!out_v_r || !out_stall) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  logic skip_now;
  assign skip_now = (o_r[0] >= lim_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      lim_r   <= UNIT_ONE;
      acc_r[0] <= UNIT_ONE; acc_r[1] <= '0; acc_r[2] <= '0; acc_r[3] <= '0;
      key_r   <= '0;
      skip_r  <= '0;
      out_v_r <= 1'b0;
      step_r  <= '0;
      comp_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) lim_r <= cfg_data;
      if (out_v_r && !out_stall && state_r != ST_OUT) out_v_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: if (accept_in) begin
          q_r[0] <= in_data.rot_w; q_r[1] <= in_data.rot_x;
          q_r[2] <= in_data.rot_y; q_r[3] <= in_data.rot_z;
          if (in_data.seq_start) begin
            acc_r[0] <= UNIT_ONE; acc_r[1] <= '0; acc_r[2] <= '0; acc_r[3] <= '0;
            key_r <= '0; skip_r <= '0;
          end
          for (int k = 0; k < 4; k++) P_r[k] <= '0;
          n2_r   <= '0;
          step_r <= '0;
        end
        ST_MUL: begin
          if (step_r[4]) begin
            for (int k = 0; k < 4; k++) p_r[k] <= rnd_p(P_r[k]);
            step_r <= '0;
            sbit_r <= '0;
          end else begin
            P_r[mi] <= msub ? P_r[mi] - 35'(mprod) : P_r[mi] + 35'(mprod);
            step_r  <= step_r + 5'd1;
          end
        end
        ST_SQRT: begin
          if (sbit_r == '0 && step_r < 5'd4) begin
            n2_r <= n2_r + 38'(mprod);
            step_r <= step_r + 5'd1;
            if (step_r == 5'd3) begin
              sv_r   <= {2'd0, n2_r + 38'(mprod), 16'd0};
              sres_r <= '0;
              sbit_r <= 56'd1 << 54;
              zero_r <= (n2_r + 38'(mprod)) == '0;
              step_r <= 5'd4;
            end
          end else if (sbit_r != '0) begin
            if ({1'b0, sv_r} >= {1'b0, sres_r} + {1'b0, sbit_r}) begin
              sv_r   <= sv_r - (sres_r + sbit_r);
              sres_r <= (sres_r >> 1) + sbit_r;
            end else begin
              sres_r <= sres_r >> 1;
            end
            sbit_r <= sbit_r >> 2;
          end else begin
            comp_r <= '0;
          end
        end
        ST_DIV: if (dv_done) begin
          o_r[comp_r] <= sat_o;
          comp_r <= comp_r + 2'd1;
        end
        ST_DONE: if (zero_r) begin
          o_r[0] <= UNIT_ONE; o_r[1] <= '0; o_r[2] <= '0; o_r[3] <= '0;
          zero_r <= 1'b0;
        end
        ST_OUT: if (!out_v_r || !out_stall) begin
          out_v_r <= 1'b1;
          if (skip_now) begin
            for (int k = 0; k < 4; k++) acc_r[k] <= o_r[k];
            out_r.out_w <= UNIT_ONE; out_r.out_x <= '0;
            out_r.out_y <= '0; out_r.out_z <= '0;
            out_r.kept <= 1'b0; out_r.key_index <= '0;
            out_r.skipped_total <= 16'((skip_r == COUNT_MAX) ? skip_r : skip_r + 1'b1);
            if (skip_r != COUNT_MAX) skip_r <= skip_r + 1'b1;
          end else begin
            out_r.out_w <= o_r[0]; out_r.out_x <= o_r[1];
            out_r.out_y <= o_r[2]; out_r.out_z <= o_r[3];
            out_r.kept <= 1'b1; out_r.key_index <= 16'(key_r);
            out_r.skipped_total <= 16'(skip_r);
            if (key_r != COUNT_MAX) key_r <= key_r + 1'b1;
            acc_r[0] <= UNIT_ONE; acc_r[1] <= '0; acc_r[2] <= '0; acc_r[3] <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

  a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> in_stall) else $error("accepting while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid) else $error("result dropped");
  a_kept_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.kept) |-> (out_data.key_index == '0))
    else $error("key index on skip");

endmodule

// ===== tb/sv/tb_quaternion_deadband_keyframer.sv =====
module tb_quaternion_deadband_keyframer;
  timeunit 1ns;
  timeprecision 1ps;
  import qdk_pkg::*;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  qdk_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  qdk_out_t out_data;
  logic     cfg_we = 1'b0;
  logic [15:0] cfg_data = '0;

  quaternion_deadband_keyframer u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // predictor state
  logic signed [15:0] cos_limit;
  logic signed [15:0] err_w, err_x, err_y, err_z;
  int unsigned        keys_seen, skips_seen;
  qdk_out_t           pending_keys[$];
  int                 errors = 0;
  int                 n_sent = 0, n_checked = 0, n_kept = 0;
  bit                 quiet = 1'b1;  // sender idles only when cleared
  bit                 hold_rx = 1'b0;

  function automatic longint round_div(longint num, longint den);
    longint mag;
    longint q;
    mag = (num < 0) ? -num : num;
    q = (mag + den / 2) / den;
    return (num < 0) ? -q : q;
  endfunction

  function automatic longint sat_word(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic longint int_sqrt(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic void clear_error();
    err_w = UNIT_ONE;
    err_x = '0;
    err_y = '0;
    err_z = '0;
  endfunction

  function automatic qdk_out_t accumulate(qdk_in_t q);
    longint pw[4], rp[4], nq[4];
    longint unsigned n2, s;
    longint qw, qx, qy, qz;
    qdk_out_t r;
    r = '0;
    if (q.seq_start) begin
      clear_error();
      keys_seen = 0;
      skips_seen = 0;
    end
    qw = q.rot_w; qx = q.rot_x; qy = q.rot_y; qz = q.rot_z;
    pw[0] = qw * err_w - qx * err_x - qy * err_y - qz * err_z;
    pw[1] = qw * err_x + qx * err_w + qy * err_z - qz * err_y;
    pw[2] = qw * err_y - qx * err_z + qy * err_w + qz * err_x;
    pw[3] = qw * err_z + qx * err_y - qy * err_x + qz * err_w;
    n2 = 0;
    for (int i = 0; i < 4; i++) begin
      rp[i] = round_div(pw[i], 64'd1 << FRAC_BITS);
      n2 += rp[i] * rp[i];
    end
    if (n2 == 0) begin
      nq[0] = UNIT_ONE;
      nq[1] = 0; nq[2] = 0; nq[3] = 0;
    end else begin
      s = int_sqrt(n2 << 16);
      for (int i = 0; i < 4; i++) nq[i] = sat_word(round_div(pw[i] * 256, s));
    end
    if (nq[0] >= cos_limit) begin
      err_w = 16'(nq[0]); err_x = 16'(nq[1]); err_y = 16'(nq[2]); err_z = 16'(nq[3]);
      if (skips_seen < 32'hFFFF) skips_seen++;
      r.out_w = UNIT_ONE;
      r.skipped_total = 16'(skips_seen);
    end else begin
      r.out_w = 16'(nq[0]); r.out_x = 16'(nq[1]);
      r.out_y = 16'(nq[2]); r.out_z = 16'(nq[3]);
      r.kept = 1'b1;
      r.key_index = 16'(keys_seen);
      r.skipped_total = 16'(skips_seen);
      if (keys_seen < 32'hFFFF) keys_seen++;
      clear_error();
    end
    return r;
  endfunction

  task automatic send_rotation(qdk_in_t q);
    qdk_out_t exp_item;
    if (!quiet) begin
      while ($urandom_range(99) < 29) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_data <= q;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    exp_item = accumulate(q);
    pending_keys = {pending_keys, exp_item};
    n_sent++;
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (pending_keys.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (200) @(posedge clk);
  endtask

  task automatic write_limit(logic signed [15:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    cos_limit = v;
  endtask

  function automatic qdk_in_t mk(int w, int x, int y, int z, bit st);
    qdk_in_t q;
    q.rot_w = 16'(w); q.rot_x = 16'(x); q.rot_y = 16'(y); q.rot_z = 16'(z);
    q.seq_start = st;
    return q;
  endfunction

  function automatic qdk_in_t random_rotation();
    qdk_in_t q;
    int mag;
    q.rot_w = 16'($urandom);
    q.rot_x = 16'($urandom);
    q.rot_y = 16'($urandom);
    q.rot_z = 16'($urandom);
    case ($urandom_range(3))
      0: ;
      default: begin
        // near-identity small steps so skips accumulate
        mag = $urandom_range(2000);
        q.rot_w = 16'(16384 - int'($urandom_range(300)));
        q.rot_x = 16'(int'($urandom_range(2 * mag)) - mag);
        q.rot_y = 16'(int'($urandom_range(2 * mag)) - mag);
        q.rot_z = 16'(int'($urandom_range(2 * mag)) - mag);
      end
    endcase
    q.seq_start = ($urandom_range(39) == 0);
    return q;
  endfunction

  task automatic test_extremes();
    send_rotation(mk(16384, 0, 0, 0, 1));
    send_rotation(mk(0, 0, 0, 0, 0));
    send_rotation(mk(32767, 32767, 32767, 32767, 0));
    send_rotation(mk(-32768, -32768, -32768, -32768, 0));
    send_rotation(mk(-16384, 0, 0, 0, 0));
    send_rotation(mk(0, 16384, 0, 0, 1));
    send_rotation(mk(0, 0, -16384, 0, 0));
    send_rotation(mk(0, 0, 0, 32767, 0));
    send_rotation(mk(1, -1, 1, -1, 0));
    send_rotation(mk(-32768, 32767, -32768, 32767, 1));
    send_rotation(mk(11585, 11585, 0, 0, 0));
  endtask

  task automatic test_limits();
    write_limit(16'sd16384);
    for (int i = 0; i < 6; i++) send_rotation(mk(16384, i * 40, 0, 0, i == 0));
    write_limit(-16'sd16384);
    for (int i = 0; i < 6; i++) send_rotation(mk(-16000, 3000, i, 0, 0));
    write_limit(16'sh8000);
    send_rotation(mk(-32768, 0, 0, 0, 0));
    write_limit(16'sh7FFF);
    send_rotation(mk(16384, 0, 0, 0, 1));
  endtask

  task automatic test_random(int count, logic signed [15:0] lim);
    write_limit(lim);
    quiet = 1'b0;
    for (int i = 0; i < count; i++) send_rotation(random_rotation());
  endtask

  task automatic test_backpressure();
    quiet = 1'b1;
    hold_rx = 1'b1;
    for (int i = 0; i < 20; i++) send_rotation(random_rotation());
    in_valid <= 1'b0;
    wait (!hold_rx);
    quiet = 1'b0;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_keys.size() == 0) begin
        $display("%0t: unexpected item, actual %h", $realtime, out_data);
        errors++;
      end else begin
        qdk_out_t e;
        e = pending_keys.pop_front();
        n_checked++;
        if (e.kept) n_kept++;
        if (e.out_w !== out_data.out_w || e.out_x !== out_data.out_x ||
            e.out_y !== out_data.out_y || e.out_z !== out_data.out_z) begin
          $display("%0t: quat mismatch expected %0d %0d %0d %0d actual %0d %0d %0d %0d",
                   $realtime, e.out_w, e.out_x, e.out_y, e.out_z, out_data.out_w,
                   out_data.out_x, out_data.out_y, out_data.out_z);
          errors++;
        end
        if (e.kept !== out_data.kept) begin
          $display("%0t: kept expected %0b actual %0b", $realtime, e.kept, out_data.kept);
          errors++;
        end
        if (e.key_index !== out_data.key_index) begin
          $display("%0t: key_index expected %0d actual %0d", $realtime, e.key_index,
                   out_data.key_index);
          errors++;
        end
        if (e.skipped_total !== out_data.skipped_total) begin
          $display("%0t: skipped_total expected %0d actual %0d", $realtime,
                   e.skipped_total, out_data.skipped_total);
          errors++;
        end
      end
    end
  end

  // receiver stalls: none for a quiet stretch, then random stalls, and a long hold-off when asked
  initial begin
    int cyc;
    cyc = 0;
    forever begin
      @(posedge clk);
      cyc++;
      if (hold_rx) begin
        out_stall <= 1'b1;
        repeat (3000) @(posedge clk);
        out_stall <= 1'b0;
        hold_rx = 1'b0;
      end else if (cyc < 20000) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < 29);
      end
    end
  end

  initial begin
    cos_limit = UNIT_ONE;
    clear_error();
    keys_seen = 0;
    skips_seen = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_extremes();
    test_limits();
    test_random(300, 16'sd16000);
    test_backpressure();
    test_random(300, 16'sd16300);
    test_random(230, 16'sd15000);
    drain();
    $display("Sent %0d items, checked %0d results, %0d of them keys,", n_sent, n_checked,
             n_kept);
    $display("across several thresholds and a long output hold-off.");
    if (errors == 0 && pending_keys.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Some tests failed");
    $finish;
  end
endmodule
